[hdl/waep_pkg.sv]
// ----------------------------------------------------------------------------
// waep_pkg
// Shared widths, types, codes and helpers for the wrap-aware envelope point
// generator.
// ----------------------------------------------------------------------------
package waep_pkg;

   localparam int TIME_BITS = 48;
   localparam int FRAC_BITS = 16;

   localparam int VAL_W   = FRAC_BITS + 1;     // Q1.FRAC_BITS value
   localparam int PROD_W  = TIME_BITS + VAL_W;  // ramp * num
   localparam int NUMER_W = PROD_W + 1;         // 2 * ramp * num + den
   localparam int DIV_W   = VAL_W + 1;          // 2 * den
   localparam int CNT_W   = $clog2(TIME_BITS);  // step counter of the scale unit

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [VAL_W-1:0]     value_type;

   localparam time_type  TIME_MAX = '1;
   localparam value_type VAL_ZERO = '0;
   localparam value_type VAL_ONE  = value_type'(1) << FRAC_BITS;
   localparam value_type VAL_HALF = value_type'(1) << (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCALE,
      ST_PLACE,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_MUL,
      PH_FORM,
      PH_DIV
   } scale_phase_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic scale_start;
      logic take_dur;
      logic place;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic wrap;
      logic den_zero;
      logic scale_done;
      logic scale_busy;
      logic out_free;
      logic pend_any;
      logic pend_last;
   } status_type;

   typedef struct packed {
      logic      new_envelope;
      time_type  start_time_ns;
      time_type  ramp_ns;
      value_type target_value;
   } req_item_type;

   typedef struct packed {
      time_type  out_time_ns;
      time_type  out_ramp_ns;
      value_type out_value;
      logic      last_of_run;
   } rsp_item_type;

   // Saturating time sum.
   function automatic time_type sat_add(time_type a, time_type b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
   endfunction

endpackage

[hdl/waep_ifs.sv]
// ----------------------------------------------------------------------------
// waep_ifs
// Valid/ready channels: automation point requests and envelope point results.
// ----------------------------------------------------------------------------
interface waep_req_if import waep_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      new_envelope;
   time_type  start_time_ns;
   time_type  ramp_ns;
   value_type target_value;

   modport source (output valid, output new_envelope, output start_time_ns,
                   output ramp_ns, output target_value, input ready);
   modport sink   (input valid, input new_envelope, input start_time_ns,
                   input ramp_ns, input target_value, output ready);
endinterface

interface waep_rsp_if import waep_pkg::*; ();
   logic      valid;
   logic      ready;
   time_type  out_time_ns;
   time_type  out_ramp_ns;
   value_type out_value;
   logic      last_of_run;

   modport source (output valid, output out_time_ns, output out_ramp_ns,
                   output out_value, output last_of_run, input ready);
   modport sink   (input valid, input out_time_ns, input out_ramp_ns,
                   input out_value, input last_of_run, output ready);
endinterface

[hdl/wrap_aware_envelope_points.sv]
// ----------------------------------------------------------------------------
// wrap_aware_envelope_points
// Turns automation points of a wrapping parameter into envelope points,
// inserting edge points where the short way round passes through 1.0 / 0.0.
// ----------------------------------------------------------------------------
// Flow: an accepted item passes through EVAL, PLACE and EMIT; a timed wrap
//   adds SCALE, where the scale unit runs its one-bit-a-cycle multiply and
//   divide. Each item gives 1 to 3 points, each put into the result register
//   in EMIT once that register is free; the next item is taken only after
//   the last point of the current one is in the result register.
// Reset: clears history, pending points and the result register; no sweep.
// ----------------------------------------------------------------------------
module wrap_aware_envelope_points import waep_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   waep_req_if.sink   req_chan,
   waep_rsp_if.source rsp_chan
);

   cmd_type      cmd;
   status_type   sts;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic         rsp_valid;

   // Gather the request payload into one item.
   assign req_item.new_envelope  = req_chan.new_envelope;
   assign req_item.start_time_ns = req_chan.start_time_ns;
   assign req_item.ramp_ns       = req_chan.ramp_ns;
   assign req_item.target_value  = req_chan.target_value;

   // Sequencer: one item in flight; ready only while waiting for the next one.
   waep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .sts       (sts),
      .req_ready (req_chan.ready),
      .cmd       (cmd)
   );

   // Datapath: history, wrap test, scale unit and the result register,
   // which lets a finished point wait while the next item is taken.
   waep_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Drive the result channel from the result register.
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.out_time_ns = rsp_item.out_time_ns;
   assign rsp_chan.out_ramp_ns = rsp_item.out_ramp_ns;
   assign rsp_chan.out_value   = rsp_item.out_value;
   assign rsp_chan.last_of_run = rsp_item.last_of_run;

   // One item at a time: ready drops right after an accept.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("item accepted while previous item in flight");

   // Never overwrite a result that has not been taken.
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result register overwritten");

   // A new item finds no leftover points and an idle scale unit.
   a_clean_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !sts.pend_any && !sts.scale_busy)
      else $error("new item taken with work still pending");

endmodule

[hdl/waep_scale.sv]
// ----------------------------------------------------------------------------
// waep_scale
// Iterative round-half-up scaling: dur = floor((2*ramp*num + den) / (2*den)).
// Shift-add multiply one bit a cycle, then restoring divide one bit a cycle.
// ----------------------------------------------------------------------------
module waep_scale import waep_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  time_type  ramp,
   input  value_type num,
   input  value_type den,
   output logic      busy,
   output logic      done,
   output time_type  dur
);

   scale_phase_type     phase_ff, phase_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   time_type            mcand_ff, mcand_in;
   value_type           mplier_ff, mplier_in;
   value_type           den_ff, den_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   time_type            quo_ff, quo_in;
   logic                done_ff, done_in;

   logic [PROD_W-1:0]   addend;
   logic [NUMER_W-1:0]  numer;
   logic [DIV_W:0]      trial;
   logic [DIV_W:0]      divisor;
   logic [DIV_W:0]      diff;
   logic                ge;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      den_ff    <= den_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
   end

   always_comb begin
      addend  = mplier_ff[VAL_W-1] ? PROD_W'(mcand_ff) : '0;
      numer   = {acc_ff, 1'b0} + NUMER_W'(den_ff);
      trial   = {rem_ff, quo_ff[TIME_BITS-1]};
      divisor = {1'b0, den_ff, 1'b0};
      ge      = (trial >= divisor);
      diff    = trial - divisor;

      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      den_in    = den_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      done_in   = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               mcand_in  = ramp;
               mplier_in = num;
               den_in    = den;
               acc_in    = '0;
               cnt_in    = CNT_W'(VAL_W - 1);
               phase_in  = PH_MUL;
            end
         end
         PH_MUL: begin
            acc_in    = {acc_ff[PROD_W-2:0], 1'b0} + addend;
            mplier_in = {mplier_ff[VAL_W-2:0], 1'b0};
            if (cnt_ff == '0) begin
               phase_in = PH_FORM;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         PH_FORM: begin
            // quotient fits TIME_BITS, so the top bits already sit below the divisor
            rem_in   = numer[NUMER_W-1:TIME_BITS];
            quo_in   = numer[TIME_BITS-1:0];
            cnt_in   = CNT_W'(TIME_BITS - 1);
            phase_in = PH_DIV;
         end
         PH_DIV: begin
            rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_in = {quo_ff[TIME_BITS-2:0], ge};
            if (cnt_ff == '0) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign busy = (phase_ff != PH_IDLE);
   assign done = done_ff;
   assign dur  = quo_ff;

endmodule

[hdl/waep_dp.sv]
// ----------------------------------------------------------------------------
// waep_dp
// Datapath: item capture, envelope history, wrap test, point placement and
// the result register.
// ----------------------------------------------------------------------------
module waep_dp import waep_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  req_item_type req_item,
   input  logic         rsp_ready,
   output status_type   sts,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   localparam int PT_FIRST = 0;   // leading point or edge point on the way out
   localparam int PT_EDGE  = 1;   // jump to the opposite edge
   localparam int PT_MAIN  = 2;   // the point itself

   // captured item
   logic         newenv_ff;
   time_type     start_ff;
   time_type     ramp_ff;
   value_type    cur_ff;
   // history
   logic         have_prev_ff, have_prev_in;
   value_type    prev_value_ff;
   time_type     prev_end_ff;
   // evaluation
   logic         first_ff;
   logic         down_ff;
   logic         wrap_ff;
   time_type     cur_end_ff;
   time_type     dur_ff;
   time_type     wt_ff;
   logic [2:0]   mask_ff, mask_in;
   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;

   logic         hp;
   value_type    cur_sat;
   value_type    wrap_dn, dist_dn, wrap_up, dist_up;
   logic         down, up;
   value_type    num, den;
   time_type     wt;
   value_type    e1, e2;
   logic [2:0]   place_mask;
   rsp_item_type next_item;
   logic         scale_busy, scale_done;
   time_type     scale_dur;

   waep_scale u_scale (
      .clock (clock),
      .reset (reset),
      .start (cmd.scale_start),
      .ramp  (ramp_ff),
      .num   (num),
      .den   (den),
      .busy  (scale_busy),
      .done  (scale_done),
      .dur   (scale_dur)
   );

   always_comb begin
      cur_sat = (req_item.target_value > VAL_ONE) ? VAL_ONE : req_item.target_value;
      hp      = have_prev_ff & ~newenv_ff;

      wrap_dn = cur_ff + (VAL_ONE - prev_value_ff);
      dist_dn = prev_value_ff - cur_ff;
      wrap_up = prev_value_ff + (VAL_ONE - cur_ff);
      dist_up = cur_ff - prev_value_ff;
      down    = hp && (prev_value_ff > VAL_HALF) && (cur_ff < VAL_HALF) && (wrap_dn < dist_dn);
      up      = hp && (cur_ff > VAL_HALF) && (prev_value_ff < VAL_HALF) && (wrap_up < dist_up);
      num     = down ? (VAL_ONE - prev_value_ff) : prev_value_ff;
      den     = down ? wrap_dn : wrap_up;

      wt = sat_add(start_ff, dur_ff);
      e1 = down_ff ? VAL_ONE : VAL_ZERO;
      e2 = down_ff ? VAL_ZERO : VAL_ONE;

      place_mask           = '0;
      place_mask[PT_FIRST] = (first_ff && (ramp_ff != '0)) ||
                             (wrap_ff && ((prev_end_ff != start_ff) || (prev_value_ff != e1)));
      place_mask[PT_EDGE]  = wrap_ff && ((cur_end_ff != wt) || (cur_ff != e2));
      place_mask[PT_MAIN]  = 1'b1;

      // lowest pending point goes out next
      next_item = '0;
      mask_in   = mask_ff;
      if (mask_ff[PT_FIRST]) begin
         next_item.out_time_ns = start_ff;
         next_item.out_ramp_ns = first_ff ? TIME_MAX & '0 : dur_ff;
         next_item.out_value   = first_ff ? cur_ff : e1;
         next_item.last_of_run = ~|mask_ff[PT_MAIN:PT_EDGE];
         mask_in[PT_FIRST]     = 1'b0;
      end else if (mask_ff[PT_EDGE]) begin
         next_item.out_time_ns = wt_ff;
         next_item.out_ramp_ns = '0;
         next_item.out_value   = e2;
         next_item.last_of_run = ~mask_ff[PT_MAIN];
         mask_in[PT_EDGE]      = 1'b0;
      end else begin
         next_item.out_time_ns = start_ff;
         next_item.out_ramp_ns = ramp_ff;
         next_item.out_value   = cur_ff;
         next_item.last_of_run = 1'b1;
         mask_in[PT_MAIN]      = 1'b0;
      end
      if (cmd.place) begin
         mask_in = place_mask;
      end else if (!cmd.emit) begin
         mask_in = mask_ff;
      end

      have_prev_in = cmd.place ? 1'b1 : have_prev_ff;

      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         prev_value_ff <= '0;
         prev_end_ff   <= '0;
         mask_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
         if (cmd.place) begin
            prev_value_ff <= cur_ff;
            prev_end_ff   <= cur_end_ff;
         end
      end
      if (cmd.load) begin
         newenv_ff <= req_item.new_envelope;
         start_ff  <= req_item.start_time_ns;
         ramp_ff   <= req_item.ramp_ns;
         cur_ff    <= cur_sat;
      end
      if (cmd.eval) begin
         first_ff   <= ~hp;
         down_ff    <= down;
         wrap_ff    <= down | up;
         cur_end_ff <= sat_add(start_ff, ramp_ff);
         dur_ff     <= '0;
      end
      if (cmd.take_dur) begin
         dur_ff <= scale_dur;
      end
      if (cmd.place) begin
         wt_ff <= wt;
      end
      if (cmd.emit) begin
         out_item_ff <= next_item;
      end
   end

   assign sts.wrap       = down | up;
   assign sts.den_zero   = (den == '0);
   assign sts.scale_done = scale_done;
   assign sts.scale_busy = scale_busy;
   assign sts.out_free   = ~out_valid_ff | rsp_ready;
   assign sts.pend_any   = |mask_ff;
   assign sts.pend_last  = (mask_ff != '0) && ((mask_ff & (mask_ff - 3'd1)) == '0);

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

[hdl/waep_ctrl.sv]
// ----------------------------------------------------------------------------
// waep_ctrl
// Sequencer: take an item, evaluate it, run the scale unit when a wrap needs
// a timed edge, place the points and hand them to the result register.
// ----------------------------------------------------------------------------
module waep_ctrl import waep_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type sts,
   output logic       req_ready,
   output cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.wrap && !sts.den_zero) begin
               cmd.scale_start = 1'b1;
               state_in        = ST_SCALE;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_SCALE: begin
            if (sts.scale_done) begin
               cmd.take_dur = 1'b1;
               state_in     = ST_PLACE;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.pend_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
